### src/adpcmd_pkg.sv
// Shared types, constants and register indexes for the four-bit ADPCM decoder.
package adpcmd_pkg;

  // Field widths fixed by the stream format.
  localparam int ByteW    = 8;
  localparam int NibW     = 4;
  localparam int PredW    = 3;
  localparam int ScaleW   = 4;
  localparam int SampleW  = 16;
  localparam int CountW   = 16;
  localparam int GroupW   = 3;
  localparam int CoefRegW = 64;
  localparam int CoefRegs = 4;
  localparam int CfgIdxW  = 3;

  // Datapath constants of the sample equation.
  localparam int AccW     = 35;
  localparam int FracBits = 11;
  localparam int RoundAdd = 1024;
  localparam int PcmMax   = 32767;
  localparam int PcmMin   = -32768;

  // Job queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_COEF_01   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_23   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_45   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_67   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HIST_ONE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HIST_TWO  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SMP_COUNT = 3'd6;

  // Input word: one stream byte.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
  } code_word_t;

  // Output word: one decoded sample.
  typedef struct packed {
    logic signed [SampleW-1:0] pcm_sample;
    logic                      last_of_byte;
    logic                      last_of_frame;
  } pcm_word_t;

  // Kinds of work handed from the front part to the back part.
  typedef enum logic {
    JOB_LOAD   = 1'b0,
    JOB_SAMPLE = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [NibW-1:0]   nibble;
    logic [PredW-1:0]  pred;
    logic [ScaleW-1:0] scale;
    logic              last_of_byte;
    logic              last_of_frame;
  } job_t;

  // Push side of the job queue.
  typedef struct packed {
    logic push;
    job_t job;
  } job_push_t;

endpackage

### src/adpcm_four_bit_decoder_unit.sv
// Top level of the four-bit ADPCM decoder: configuration registers and part wiring.
//
// Decodes one channel of four-bit ADPCM, one stream byte per input word. A frame
// starts on a word with frame_start set; that byte is the group header. In steady
// state a data byte yields up to two samples, high nibble first, and the next byte
// enters as its last job is queued. While the output does not stall, the front part
// hands one job per cycle into a four-entry queue and the back part turns one
// nibble into one sample per cycle with two 16x16 multiplies on the history
// registers. A header byte takes no queue slot, except at frame start,
// where it queues a history reload. Registers are written through
// cfg_write/cfg_index/cfg_data; write them only while the block is idle. There is
// no reset sweep: the block is ready in the first cycle after rst.
module adpcm_four_bit_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               code_valid,
  output logic                               code_stall,
  input  adpcmd_pkg::code_word_t             code_word,
  output logic                               pcm_valid,
  input  logic                               pcm_stall,
  output adpcmd_pkg::pcm_word_t              pcm_word,
  input  logic                               cfg_write,
  input  logic [adpcmd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [adpcmd_pkg::CoefRegW-1:0]    cfg_data
);

  logic [adpcmd_pkg::CoefRegW-1:0]       coef_regs [adpcmd_pkg::CoefRegs];
  logic signed [adpcmd_pkg::SampleW-1:0] first_history_init;
  logic signed [adpcmd_pkg::SampleW-1:0] second_history_init;
  logic [adpcmd_pkg::CountW-1:0]         sample_count;

  adpcmd_pkg::job_push_t q_in;
  logic                  q_full;
  logic                  q_valid;
  adpcmd_pkg::job_t      q_job;
  logic                  q_pop;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_regs[0]        <= '0;
      coef_regs[1]        <= '0;
      coef_regs[2]        <= '0;
      coef_regs[3]        <= '0;
      first_history_init  <= '0;
      second_history_init <= '0;
      sample_count        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        adpcmd_pkg::REG_COEF_01:   coef_regs[0] <= cfg_data;
        adpcmd_pkg::REG_COEF_23:   coef_regs[1] <= cfg_data;
        adpcmd_pkg::REG_COEF_45:   coef_regs[2] <= cfg_data;
        adpcmd_pkg::REG_COEF_67:   coef_regs[3] <= cfg_data;
        adpcmd_pkg::REG_HIST_ONE:  first_history_init  <= signed'(cfg_data[15:0]);
        adpcmd_pkg::REG_HIST_TWO:  second_history_init <= signed'(cfg_data[15:0]);
        adpcmd_pkg::REG_SMP_COUNT: sample_count <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  adpcmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_word    (code_word),
    .sample_count (sample_count),
    .q_full       (q_full),
    .q_in         (q_in)
  );

  adpcmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop)
  );

  adpcmd_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_job               (q_job),
    .q_pop               (q_pop),
    .coef_regs           (coef_regs),
    .first_history_init  (first_history_init),
    .second_history_init (second_history_init),
    .pcm_valid           (pcm_valid),
    .pcm_stall           (pcm_stall),
    .pcm_word            (pcm_word)
  );

endmodule

### src/adpcmd_front.sv
// Front part: takes stream bytes, tracks group position and sample count, emits jobs.
module adpcmd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              code_valid,
  output logic                              code_stall,
  input  adpcmd_pkg::code_word_t            code_word,
  input  logic [adpcmd_pkg::CountW-1:0]     sample_count,
  input  logic                              q_full,
  output adpcmd_pkg::job_push_t             q_in
);

  logic [adpcmd_pkg::GroupW-1:0] group_position;
  logic [adpcmd_pkg::CountW-1:0] samples_done;
  logic [adpcmd_pkg::PredW-1:0]  predictor_index;
  logic [adpcmd_pkg::ScaleW-1:0] shift_scale;

  // Up to two jobs wait here per byte.
  logic [1:0]         pend_cnt;
  adpcmd_pkg::job_t   pend0;
  adpcmd_pkg::job_t   pend1;

  logic                          accept;
  logic                          push;
  logic [adpcmd_pkg::GroupW-1:0] gp_eff;
  logic [adpcmd_pkg::CountW-1:0] sd_eff;
  logic [adpcmd_pkg::CountW-1:0] sd_one;
  logic [adpcmd_pkg::CountW-1:0] sd_two;
  logic [adpcmd_pkg::CountW-1:0] samples_done_next;
  logic [adpcmd_pkg::PredW-1:0]  predictor_index_next;
  logic [adpcmd_pkg::ScaleW-1:0] shift_scale_next;
  logic                          hi_ok;
  logic                          lo_ok;
  logic [1:0]                    njobs;
  adpcmd_pkg::job_t              job_a;
  adpcmd_pkg::job_t              job_b;

  // Handshake: a new byte enters once the pending jobs drain this cycle.
  assign push       = (pend_cnt != 2'd0) && !q_full;
  assign code_stall = !((pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && push));
  assign accept     = code_valid && !code_stall;
  assign q_in.push  = push;
  assign q_in.job   = pend0;

  // Classify the byte: frame start, header, or up to two nibbles.
  always_comb begin
    gp_eff = code_word.frame_start ? '0 : group_position;
    sd_eff = code_word.frame_start ? '0 : samples_done;
    sd_one = sd_eff + 1'b1;
    sd_two = sd_eff + 2'd2;
    hi_ok  = 1'b0;
    lo_ok  = 1'b0;
    predictor_index_next = predictor_index;
    shift_scale_next     = shift_scale;
    njobs  = 2'd0;

    job_a.kind          = adpcmd_pkg::JOB_SAMPLE;
    job_a.nibble        = code_word.data_byte[7:4];
    job_a.pred          = predictor_index;
    job_a.scale         = shift_scale;
    job_a.last_of_frame = (sd_one == sample_count);
    job_a.last_of_byte  = (sd_one == sample_count);
    job_b.kind          = adpcmd_pkg::JOB_SAMPLE;
    job_b.nibble        = code_word.data_byte[3:0];
    job_b.pred          = predictor_index;
    job_b.scale         = shift_scale;
    job_b.last_of_frame = (sd_two == sample_count);
    job_b.last_of_byte  = 1'b1;

    if (gp_eff == '0) begin
      predictor_index_next = code_word.data_byte[6:4];
      shift_scale_next     = code_word.data_byte[3:0];
      if (code_word.frame_start) begin
        job_a.kind = adpcmd_pkg::JOB_LOAD;
        njobs      = 2'd1;
      end
    end else begin
      hi_ok = (sd_eff < sample_count);
      lo_ok = hi_ok && (sd_one < sample_count);
      njobs = {1'b0, hi_ok} + {1'b0, lo_ok};
    end
    samples_done_next = sd_eff + {14'd0, njobs & {2{gp_eff != '0}}};
  end

  // Stream position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= '0;
      samples_done    <= '0;
      predictor_index <= '0;
      shift_scale     <= '0;
    end else if (accept) begin
      group_position  <= gp_eff + 1'b1;
      samples_done    <= samples_done_next;
      predictor_index <= predictor_index_next;
      shift_scale     <= shift_scale_next;
    end
  end

  // Pending job slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      pend_cnt <= njobs;
    end else if (push) begin
      pend_cnt <= pend_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend0 <= job_a;
      pend1 <= job_b;
    end else if (push) begin
      pend0 <= pend1;
    end
  end

  // The pending buffer holds at most two jobs.
  assert property (@(posedge clk) disable iff (rst) pend_cnt != 2'd3)
    else $error("front pending count out of range");

  // The sample count moves only when a byte is taken.
  assert property (@(posedge clk) disable iff (rst) !accept |=> $stable(samples_done))
    else $error("samples_done changed without an accepted word");

endmodule

### src/adpcmd_queue.sv
// Short job queue that decouples the front part from the back part.
module adpcmd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  adpcmd_pkg::job_push_t q_in,
  output logic                  q_full,
  output logic                  q_valid,
  output adpcmd_pkg::job_t      q_job,
  input  logic                  q_pop
);

  adpcmd_pkg::job_t                 entries [adpcmd_pkg::QDepth];
  logic [adpcmd_pkg::QPtrW-1:0]     wr_ptr;
  logic [adpcmd_pkg::QPtrW-1:0]     rd_ptr;
  logic [adpcmd_pkg::QCntW-1:0]     count;
  logic                             do_push;
  logic                             do_pop;

  assign q_full  = (count == adpcmd_pkg::QCntW'(adpcmd_pkg::QDepth));
  assign q_valid = (count != '0);
  assign q_job   = entries[rd_ptr];
  assign do_push = q_in.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == adpcmd_pkg::QPtrW'(adpcmd_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == adpcmd_pkg::QPtrW'(adpcmd_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_in.job;
    end
  end

  // The front part never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_in.push |-> !q_full)
    else $error("job pushed into a full queue");

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst)
                   count <= adpcmd_pkg::QCntW'(adpcmd_pkg::QDepth))
    else $error("queue count out of range");

endmodule

### src/adpcmd_back.sv
// Back part: history registers, predictor arithmetic and the output register.
module adpcmd_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  adpcmd_pkg::job_t                       q_job,
  output logic                                   q_pop,
  input  logic [adpcmd_pkg::CoefRegW-1:0]        coef_regs [adpcmd_pkg::CoefRegs],
  input  logic signed [adpcmd_pkg::SampleW-1:0]  first_history_init,
  input  logic signed [adpcmd_pkg::SampleW-1:0]  second_history_init,
  output logic                                   pcm_valid,
  input  logic                                   pcm_stall,
  output adpcmd_pkg::pcm_word_t                  pcm_word
);

  logic signed [adpcmd_pkg::SampleW-1:0] history_one;
  logic signed [adpcmd_pkg::SampleW-1:0] history_two;

  logic [adpcmd_pkg::CoefRegW-1:0]       coef_reg;
  logic signed [adpcmd_pkg::SampleW-1:0] c1;
  logic signed [adpcmd_pkg::SampleW-1:0] c2;
  logic signed [2*adpcmd_pkg::SampleW-1:0] prod_one;
  logic signed [2*adpcmd_pkg::SampleW-1:0] prod_two;
  logic signed [adpcmd_pkg::NibW-1:0]    nib;
  logic [4:0]                            shamt;
  logic signed [adpcmd_pkg::AccW-1:0]    acc;
  logic signed [adpcmd_pkg::AccW-1:0]    scaled;
  logic signed [adpcmd_pkg::SampleW-1:0] sat;
  logic                                  take_load;
  logic                                  take_sample;

  // Pop a load at once; pop a sample when the output register frees up.
  assign take_load   = q_valid && (q_job.kind == adpcmd_pkg::JOB_LOAD);
  assign take_sample = q_valid && (q_job.kind == adpcmd_pkg::JOB_SAMPLE)
                       && (!pcm_valid || !pcm_stall);
  assign q_pop       = take_load || take_sample;

  // Coefficient pair for the job's predictor.
  always_comb begin
    coef_reg = coef_regs[q_job.pred[2:1]];
    if (q_job.pred[0]) begin
      c1 = signed'(coef_reg[31:16]);
      c2 = signed'(coef_reg[15:0]);
    end else begin
      c1 = signed'(coef_reg[63:48]);
      c2 = signed'(coef_reg[47:32]);
    end
  end

  // Prediction plus scaled nibble, rounded, shifted and saturated.
  always_comb begin
    prod_one = c1 * history_one;
    prod_two = c2 * history_two;
    nib      = signed'(q_job.nibble);
    shamt    = {1'b0, q_job.scale} + 5'(adpcmd_pkg::FracBits);
    acc      = adpcmd_pkg::AccW'(prod_one) + adpcmd_pkg::AccW'(prod_two)
             + (adpcmd_pkg::AccW'(nib) <<< shamt)
             + adpcmd_pkg::AccW'(adpcmd_pkg::RoundAdd);
    scaled   = acc >>> adpcmd_pkg::FracBits;
    if (scaled > adpcmd_pkg::AccW'(adpcmd_pkg::PcmMax)) begin
      sat = adpcmd_pkg::SampleW'(adpcmd_pkg::PcmMax);
    end else if (scaled < adpcmd_pkg::AccW'(adpcmd_pkg::PcmMin)) begin
      sat = adpcmd_pkg::SampleW'(adpcmd_pkg::PcmMin);
    end else begin
      sat = scaled[adpcmd_pkg::SampleW-1:0];
    end
  end

  // History registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      history_one <= '0;
      history_two <= '0;
    end else if (take_load) begin
      history_one <= first_history_init;
      history_two <= second_history_init;
    end else if (take_sample) begin
      history_one <= sat;
      history_two <= history_one;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcm_valid <= 1'b0;
    end else if (take_sample) begin
      pcm_valid <= 1'b1;
    end else if (!pcm_stall) begin
      pcm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      pcm_word.pcm_sample    <= sat;
      pcm_word.last_of_byte  <= q_job.last_of_byte;
      pcm_word.last_of_frame <= q_job.last_of_frame;
    end
  end

  // A new sample only enters the output register when it is free or draining.
  assert property (@(posedge clk) disable iff (rst) take_sample |-> (!pcm_valid || !pcm_stall))
    else $error("output word overwritten while stalled");

  // A sample taken from the queue becomes the history for the next one.
  assert property (@(posedge clk) disable iff (rst)
                   take_sample |=> (history_one == pcm_word.pcm_sample))
    else $error("history does not follow the emitted sample");

endmodule

### verif/adpcm_four_bit_decoder_unit_tb.sv
// Self-checking testbench for the four-bit ADPCM decoder: stream bytes in, checked PCM words out.
`timescale 1ns / 100ps

module adpcm_four_bit_decoder_unit_tb;

  localparam int RandomBytes  = 1700;
  localparam int DirectedMax  = 25;
  localparam int SettleCycles = 10;

  logic                                clk        = 1'b0;
  logic                                rst        = 1'b1;
  logic                                code_valid = 1'b0;
  logic                                code_stall;
  adpcmd_pkg::code_word_t              code_word  = '0;
  logic                                pcm_valid;
  logic                                pcm_stall  = 1'b0;
  adpcmd_pkg::pcm_word_t               pcm_word;
  logic                                cfg_write  = 1'b0;
  logic [adpcmd_pkg::CfgIdxW-1:0]      cfg_index  = '0;
  logic [adpcmd_pkg::CoefRegW-1:0]     cfg_data   = '0;

  // When set, the sender adds no random gaps and the output side never stalls.
  bit calm = 1'b0;
  int bytes_sent = 0;
  int frames_started = 0;
  int settings = 0;
  logic [adpcmd_pkg::CountW-1:0] cur_count = '0;

  // Tracks the decoder state and holds the samples each accepted byte should yield.
  class decoded_sample_book;
    logic [adpcmd_pkg::CoefRegW-1:0]       coef_reg [adpcmd_pkg::CoefRegs];
    logic signed [adpcmd_pkg::SampleW-1:0] init_one, init_two, hist_one, hist_two;
    logic [adpcmd_pkg::CountW-1:0]         frame_len, done_count;
    logic [adpcmd_pkg::PredW-1:0]          pred;
    logic [adpcmd_pkg::ScaleW-1:0]         scale;
    logic [adpcmd_pkg::GroupW-1:0]         group_pos;
    adpcmd_pkg::pcm_word_t                 pending_pcm [$];
    int                                    errors;
    int                                    checked;

    function new();
      foreach (coef_reg[i]) coef_reg[i] = '0;
      init_one = '0;
      init_two = '0;
      hist_one = '0;
      hist_two = '0;
      frame_len = '0;
      done_count = '0;
      pred = '0;
      scale = '0;
      group_pos = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(logic [adpcmd_pkg::CfgIdxW-1:0] idx,
                               logic [adpcmd_pkg::CoefRegW-1:0] value);
      case (idx)
        adpcmd_pkg::REG_COEF_01:   coef_reg[0] = value;
        adpcmd_pkg::REG_COEF_23:   coef_reg[1] = value;
        adpcmd_pkg::REG_COEF_45:   coef_reg[2] = value;
        adpcmd_pkg::REG_COEF_67:   coef_reg[3] = value;
        adpcmd_pkg::REG_HIST_ONE:  init_one = value[adpcmd_pkg::SampleW-1:0];
        adpcmd_pkg::REG_HIST_TWO:  init_two = value[adpcmd_pkg::SampleW-1:0];
        adpcmd_pkg::REG_SMP_COUNT: frame_len = value[adpcmd_pkg::CountW-1:0];
        default: ;
      endcase
    endfunction

    // Coefficients sit high to low: c1 even, c2 even, c1 odd, c2 odd.
    function logic signed [adpcmd_pkg::SampleW-1:0] coef(bit second);
      logic [adpcmd_pkg::CoefRegW-1:0] r;
      int slot;
      r = coef_reg[pred[2:1]];
      slot = int'({pred[0], second});
      return r[(3 - slot) * 16 +: 16];
    endfunction

    // One step of the history recurrence, rounded, floored and saturated.
    function logic signed [adpcmd_pkg::SampleW-1:0] next_sample(
        logic [adpcmd_pkg::NibW-1:0] nib);
      longint c1, c2, n, acc;
      c1 = longint'(coef(1'b0));
      c2 = longint'(coef(1'b1));
      n = longint'($signed(nib));
      acc = c1 * longint'(hist_one) + c2 * longint'(hist_two)
          + (n <<< (int'(scale) + 11)) + adpcmd_pkg::RoundAdd;
      acc = acc >>> adpcmd_pkg::FracBits;
      if (acc > adpcmd_pkg::PcmMax) acc = adpcmd_pkg::PcmMax;
      if (acc < adpcmd_pkg::PcmMin) acc = adpcmd_pkg::PcmMin;
      hist_two = hist_one;
      hist_one = acc[adpcmd_pkg::SampleW-1:0];
      return hist_one;
    endfunction

    function void note_code_word(adpcmd_pkg::code_word_t w);
      adpcmd_pkg::pcm_word_t e;
      logic [adpcmd_pkg::NibW-1:0] nib;
      if (w.frame_start) begin
        hist_one = init_one;
        hist_two = init_two;
        group_pos = '0;
        done_count = '0;
      end
      if (group_pos == '0) begin
        pred = w.data_byte[6:4];
        scale = w.data_byte[3:0];
      end else begin
        // High nibble first; stop as soon as the frame has all its samples.
        for (int k = 0; k < 2; k++) begin
          if (done_count >= frame_len) break;
          nib = (k == 0) ? w.data_byte[7:4] : w.data_byte[3:0];
          e.pcm_sample = next_sample(nib);
          done_count++;
          e.last_of_frame = (done_count == frame_len);
          e.last_of_byte = (k == 1) || e.last_of_frame;
          pending_pcm.push_back(e);
        end
      end
      group_pos++;
    endfunction

    function void check_pcm_word(adpcmd_pkg::pcm_word_t got);
      adpcmd_pkg::pcm_word_t e;
      if (pending_pcm.size() == 0) begin
        $error("unexpected pcm word: pcm_sample %0d, last_of_byte %0b, last_of_frame %0b",
               got.pcm_sample, got.last_of_byte, got.last_of_frame);
        errors++;
        return;
      end
      e = pending_pcm.pop_front();
      checked++;
      if (got.pcm_sample !== e.pcm_sample) begin
        $error("pcm_sample: expected %0d, actual %0d", e.pcm_sample, got.pcm_sample);
        errors++;
      end
      if (got.last_of_byte !== e.last_of_byte) begin
        $error("last_of_byte: expected %0b, actual %0b", e.last_of_byte, got.last_of_byte);
        errors++;
      end
      if (got.last_of_frame !== e.last_of_frame) begin
        $error("last_of_frame: expected %0b, actual %0b", e.last_of_frame, got.last_of_frame);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_pcm.size();
    endfunction

    function void close_out();
      if (pending_pcm.size() != 0) begin
        $error("%0d expected pcm words never arrived", pending_pcm.size());
        errors++;
      end
    endfunction
  endclass

  decoded_sample_book samples = new();

  adpcm_four_bit_decoder_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_word  (code_word),
    .pcm_valid  (pcm_valid),
    .pcm_stall  (pcm_stall),
    .pcm_word   (pcm_word),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Output side: check every accepted word, then pick the next stall at random.
  always @(posedge clk) begin
    if (!rst && pcm_valid && !pcm_stall) samples.check_pcm_word(pcm_word);
    pcm_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mix of full-range, extreme and realistic fixed-point coefficients.
  function automatic logic [15:0] rand_coef();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: begin
        v = 16'($urandom_range(0, 8191));
        v = v - 16'd4096;
      end
      2: v = pick_extreme();
      default: begin
        v = 16'($urandom_range(0, 4095));
        v = v - 16'd2048;
      end
    endcase
    return v;
  endfunction

  function automatic logic [adpcmd_pkg::CoefRegW-1:0] rand_coef_word();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [15:0] pick_history();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = pick_extreme();
      1: v = 16'($urandom);
      default: begin
        v = 16'($urandom_range(0, 8191));
        v = v - 16'd4096;
      end
    endcase
    return v;
  endfunction

  // Mostly short frames, now and then a long one, an empty one or the largest count.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(41, 200));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // Presents one word with a random idle gap ahead of it and waits for acceptance.
  task automatic send_code(input logic [adpcmd_pkg::ByteW-1:0] b, input logic fs);
    adpcmd_pkg::code_word_t w;
    int gap;
    w.data_byte = b;
    w.frame_start = fs;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) gap++;
    end
    if (gap > 0) begin
      code_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_valid <= 1'b1;
    code_word <= w;
    do @(posedge clk); while (code_stall);
    samples.note_code_word(w);
    bytes_sent++;
    if (fs) frames_started++;
  endtask

  task automatic write_reg(input logic [adpcmd_pkg::CfgIdxW-1:0] idx,
                           input logic [adpcmd_pkg::CoefRegW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    samples.set_register(idx, value);
    if (idx == adpcmd_pkg::REG_SMP_COUNT) cur_count = value[adpcmd_pkg::CountW-1:0];
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(input logic [adpcmd_pkg::CoefRegW-1:0] c01, c23, c45, c67,
                             input logic [15:0] h1, h2, cnt);
    write_reg(adpcmd_pkg::REG_COEF_01, c01);
    write_reg(adpcmd_pkg::REG_COEF_23, c23);
    write_reg(adpcmd_pkg::REG_COEF_45, c45);
    write_reg(adpcmd_pkg::REG_COEF_67, c67);
    write_reg(adpcmd_pkg::REG_HIST_ONE, {48'd0, h1});
    write_reg(adpcmd_pkg::REG_HIST_TWO, {48'd0, h2});
    write_reg(adpcmd_pkg::REG_SMP_COUNT, {48'd0, cnt});
    settings++;
  endtask

  // Stop sending, wait for every expected word, then let the pipeline settle.
  task automatic quiesce();
    code_valid <= 1'b0;
    do @(posedge clk); while (samples.outstanding() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Frame of up to 120 bytes, enough for counts to 200, a few spare bytes and rare stray starts.
  task automatic random_frame(input bit reopen, input int count);
    int d, len, pause_at;
    d = (count + 1) / 2;
    len = 1 + d + (d + 6) / 7 + $urandom_range(0, 4);
    if (len > 120) len = 120;
    pause_at = -1;
    if (len > 1 && $urandom_range(0, 3) == 0) pause_at = $urandom_range(1, len - 1);
    for (int j = 0; j < len; j++) begin
      // Hold the sender back until every pending sample has drained.
      if (j == pause_at) begin
        code_valid <= 1'b0;
        do @(posedge clk); while (samples.outstanding() != 0);
      end
      send_code(adpcmd_pkg::ByteW'($urandom),
                (j == 0 && reopen) || ($urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    int phase;
    int nframes;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bytes before any frame start, with a zero count, yield nothing.
    send_code(8'hA5, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    quiesce();

    // Extreme coefficients and histories; an odd count ends the frame on a high nibble.
    program_all({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000},
                {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF},
                {16'h0800, 16'hF800, 16'h1000, 16'hF000},
                rand_coef_word(), 16'h7FFF, 16'h8000, 16'd13);
    send_code(8'h0F, 1'b1);
    send_code(8'h77, 1'b0);
    send_code(8'h88, 1'b0);
    send_code(8'h7F, 1'b0);
    send_code(8'h80, 1'b0);
    send_code(8'h01, 1'b0);
    send_code(8'hF8, 1'b0);
    send_code(8'h5A, 1'b0);
    // Next header with bit 7 set, then a byte past the end of the frame.
    send_code(8'hFF, 1'b0);
    send_code(8'h33, 1'b0);
    quiesce();

    // Raising the count mid-frame lets the same frame go on decoding.
    write_reg(adpcmd_pkg::REG_SMP_COUNT, 64'd20);
    send_code(8'h12, 1'b0);
    send_code(8'hC4, 1'b0);
    send_code(8'h6E, 1'b0);

    // A frame start in the middle of a group reloads history and restarts the group.
    send_code(8'h93, 1'b1);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h8F, 1'b0);
    quiesce();

    // Random phases: new settings while idle, then one to three frames each.
    phase = 0;
    while (bytes_sent < DirectedMax + RandomBytes) begin
      calm = (phase % 5 == 3);
      program_all(rand_coef_word(), rand_coef_word(), rand_coef_word(), rand_coef_word(),
                  pick_history(), pick_history(), pick_count());
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        random_frame(!(f == 0 && $urandom_range(0, 5) == 0), int'(cur_count));
      end
      quiesce();
      phase++;
    end
    calm = 1'b0;

    samples.close_out();
    $display("Sent %0d stream bytes with %0d frame starts over %0d register settings.",
             bytes_sent, frames_started, settings);
    $display("Compared %0d decoded samples, saturation and frame ends included.",
             samples.checked);
    if (samples.errors == 0) begin
      $display("adpcm_four_bit_decoder_unit regression: pass");
    end else begin
      $display("adpcm_four_bit_decoder_unit regression: fail");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("adpcm_four_bit_decoder_unit regression: fail");
    $finish;
  end

endmodule

### adpcm_four_bit_decoder_unit.f
src/adpcmd_pkg.sv
src/adpcmd_front.sv
src/adpcmd_queue.sv
src/adpcmd_back.sv
src/adpcm_four_bit_decoder_unit.sv
verif/adpcm_four_bit_decoder_unit_tb.sv
